[src/avoc_pkg.sv]
// Package for the adaptive voltage and oscillator trim controller.
// Holds shared constants, register indexes and the front-to-back queue entry type.
// No dependencies.
`default_nettype none
package avoc_pkg;
  localparam int BUCKETS_DEF = 64;
  localparam logic [7:0] EMPTY_VOLT = 8'd255;
  localparam logic [15:0] RESET_PERIOD = 16'd55050;
  localparam logic [7:0] RESET_TEMP = 8'd51;
  localparam logic [7:0] AFTER_RESET = 8'd2;
  localparam logic [6:0] TEMP_INVALID = 7'd101;

  localparam logic [2:0] REG_GOOD_CHK = 3'd0;
  localparam logic [2:0] REG_ADAPT = 3'd1;
  localparam logic [2:0] REG_MARGIN = 3'd2;
  localparam logic [2:0] REG_FLOOR = 3'd3;
  localparam logic [2:0] REG_CEIL = 3'd4;
  localparam logic [2:0] REG_DEADLOCK = 3'd5;
  localparam logic [2:0] REG_STARTUP = 3'd6;

  localparam logic [7:0]  GOOD_CHK_RST = 8'd62;
  localparam logic [3:0]  ADAPT_RST = 4'd10;
  localparam logic [15:0] MARGIN_RST = 16'd100;
  localparam logic [7:0]  FLOOR_RST = 8'd200;
  localparam logic [7:0]  CEIL_RST = 8'd254;
  localparam logic [3:0]  DEADLOCK_RST = 4'd5;
  localparam logic [3:0]  STARTUP_RST = 4'd7;

  typedef struct packed {
    logic       tick;
    logic [7:0] tag;
    logic [7:0] chk;
    logic [6:0] temp;
    logic [7:0] trim;
    logic [7:0] fact;
    logic [7:0] rflag;
    logic [15:0] elapsed;
  } item_t;
endpackage
`default_nettype wire

[src/avoc_front.sv]
// Front part: accepts input transfers and filters repeated frame tags.
// Pushes surviving items into a two-entry queue. Depends on avoc_pkg.
`default_nettype none
module avoc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire avoc_pkg::item_t in_item,
  input  wire logic           pop,
  output logic                q_valid,
  output avoc_pkg::item_t     q_item
);
  avoc_pkg::item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic [7:0] last_tag_r;
  logic       acc, push, do_pop;

  assign in_stall = (cnt_r == 2'd2);
  assign acc = in_valid && !in_stall;
  assign push = acc && (in_item.tick || in_item.tag != last_tag_r);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rd_r];
  assign do_pop = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      last_tag_r <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      if (acc && !in_item.tick) last_tag_r <= in_item.tag;
    end
    if (push) q_r[wr_r] <= in_item;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) do_pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !do_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
endmodule
`default_nettype wire

[src/avoc_back.sv]
// Back part: executes ticks and frames against the control state and bucket memory.
// Each item takes a table read, with the after-reset write, then an update and write-back; one item at a time.
// Depends on avoc_pkg.
`default_nettype none
module avoc_back #(
  parameter int BUCKETS = avoc_pkg::BUCKETS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire avoc_pkg::item_t q_item,
  output logic                 pop,
  input  wire logic [7:0]      good_checksum,
  input  wire logic [3:0]      adapt_interval,
  input  wire logic [15:0]     period_margin,
  input  wire logic [7:0]      voltage_floor,
  input  wire logic [7:0]      voltage_ceiling,
  input  wire logic [3:0]      deadlock_limit,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_trim_feedback,
  output logic [7:0]           out_voltage_code,
  output logic [15:0]          out_period_report,
  output logic [5:0]           out_debug_bucket,
  output logic                 out_deadlock_reset,
  output logic                 out_temp_invalid
);
  localparam int BW = $clog2(BUCKETS);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001, S_READ = 3'b010, S_EXEC = 3'b100
  } state_t;

  state_t st_r, st_nxt;
  logic [15:0] mem [BUCKETS];
  logic [BUCKETS-1:0] vld_r;
  logic [15:0] rd_data_r;
  logic        rd_vld_r;
  logic [BW-1:0] raddr;

  logic       phase_r, phase_nxt;
  logic [3:0] sl_r, sl_nxt, ac_r, ac_nxt, oc_r, oc_nxt;
  logic [15:0] refp_r, refp_nxt;
  logic [7:0] vn_r, vn_nxt, tn_r, tn_nxt, tb_r, tb_nxt, tl_r, tl_nxt, td_r, td_nxt;
  logic [7:0] rt_r, rt_nxt, rv_r, rv_nxt, rdbg_r, rdbg_nxt;
  logic [15:0] rp_r, rp_nxt;
  logic       ov_r, ov_nxt, odl_r, odl_nxt, oti_r, oti_nxt;

  logic        we;
  logic [BW-1:0] wa;
  logic [15:0] wd;
  logic [7:0]  tv, tt;
  logic        out_free;

  function automatic logic [BW-1:0] bucket_of(input logic [7:0] t);
    logic [7:0] b;
    b = {1'b0, t[7:1]};
    if (32'(b) >= BUCKETS) bucket_of = BW'(BUCKETS - 1);
    else bucket_of = b[BW-1:0];
  endfunction

  assign out_free = !ov_r || !out_stall;
  assign tv = rd_vld_r ? rd_data_r[15:8] : avoc_pkg::EMPTY_VOLT;
  assign tt = rd_vld_r ? rd_data_r[7:0] : 8'd0;
  assign pop = (st_r == S_EXEC) && out_free;

  always_comb begin
    logic [BW-1:0] b;
    logic [16:0] hi, lo;
    logic [4:0]  n;
    logic [8:0]  v1;
    st_nxt = st_r;
    phase_nxt = phase_r; sl_nxt = sl_r; ac_nxt = ac_r; oc_nxt = oc_r;
    refp_nxt = refp_r; vn_nxt = vn_r; tn_nxt = tn_r; tb_nxt = tb_r;
    tl_nxt = tl_r; td_nxt = td_r; rt_nxt = rt_r; rv_nxt = rv_r; rp_nxt = rp_r;
    rdbg_nxt = rdbg_r;
    ov_nxt = ov_r && out_stall; odl_nxt = odl_r; oti_nxt = oti_r;
    we = 1'b0; wa = '0; wd = '0;
    b = '0; hi = '0; lo = '0; n = '0; v1 = '0;
    unique case (st_r)
      S_CLEAR: st_nxt = S_READ;
      S_READ: begin
        if (q_valid) begin
          st_nxt = S_EXEC;
          if (!q_item.tick && q_item.tag == avoc_pkg::AFTER_RESET) begin
            we = 1'b1; wa = bucket_of(tn_r); wd = {vn_r - 8'd2, tl_r};
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          st_nxt = S_READ;
          if (q_item.tick) begin
            oc_nxt = (oc_r == 4'd15) ? oc_r : oc_r + 4'd1;
            if (oc_nxt > deadlock_limit) begin
              vn_nxt = voltage_floor;
              tl_nxt = td_r;
              if (tv != avoc_pkg::EMPTY_VOLT) begin
                we = 1'b1; wa = bucket_of(tn_r); wd = {avoc_pkg::EMPTY_VOLT, td_r};
                rdbg_nxt = 8'(wa);
              end
              oc_nxt = 4'd0;
              ov_nxt = 1'b1; odl_nxt = 1'b1; oti_nxt = 1'b0;
            end
          end else begin
            oc_nxt = 4'd0;
            td_nxt = q_item.fact;
            if (q_item.temp == avoc_pkg::TEMP_INVALID) begin
              if (q_item.tag == avoc_pkg::AFTER_RESET) rdbg_nxt = 8'(bucket_of(tn_r));
              ov_nxt = 1'b1; odl_nxt = 1'b0; oti_nxt = 1'b1;
            end else begin
              tl_nxt = q_item.trim;
              vn_nxt = (q_item.rflag == avoc_pkg::AFTER_RESET) ? vn_r - 8'd2 : vn_r;
              tn_nxt = {1'b0, q_item.temp};
              b = bucket_of(tn_nxt);
              if (q_item.tag == avoc_pkg::AFTER_RESET) rdbg_nxt = 8'(bucket_of(tn_r));
              if (!phase_r) begin
                if (sl_r != 4'd0) begin
                  sl_nxt = sl_r - 4'd1;
                  refp_nxt = q_item.elapsed; rp_nxt = q_item.elapsed;
                end else phase_nxt = 1'b1;
                rt_nxt = tl_nxt;
                n = {1'b0, ac_r} + 5'd1;
                if (q_item.chk != good_checksum) vn_nxt = vn_nxt - 8'd2;
                else if (n > {1'b0, adapt_interval}) begin
                  vn_nxt = vn_nxt + 8'd1; ac_nxt = 4'd0;
                end else ac_nxt = n[3:0];
                rv_nxt = vn_nxt;
                tb_nxt = tn_nxt;
              end else begin
                hi = {1'b0, refp_r} + {1'b0, period_margin};
                lo = {1'b0, refp_r} - {1'b0, period_margin};
                rp_nxt = q_item.elapsed;
                if ({1'b0, q_item.elapsed} > hi) rt_nxt = tl_nxt + 8'd1;
                else if (!lo[16] && {1'b0, q_item.elapsed} < lo) rt_nxt = tl_nxt - 8'd1;
                else rt_nxt = tl_nxt;
                n = {1'b0, ac_r} + 5'd1;
                if (q_item.chk != good_checksum) begin
                  if ({1'b0, vn_nxt} < {1'b0, voltage_floor} + 9'd2) begin
                    vn_nxt = voltage_floor; rt_nxt = q_item.fact;
                    wd = {avoc_pkg::EMPTY_VOLT, tl_nxt};
                  end else begin
                    vn_nxt = vn_nxt - 8'd2;
                    wd = {vn_nxt, tl_nxt};
                  end
                  we = 1'b1; wa = b; rdbg_nxt = 8'(b);
                  tb_nxt = tn_nxt;
                end else if (tv != avoc_pkg::EMPTY_VOLT) begin
                  vn_nxt = tv; rt_nxt = tt; tb_nxt = tn_nxt;
                end else if ({1'b0, tn_nxt} + 9'd2 < {1'b0, tb_r}) begin
                  vn_nxt = voltage_floor; tb_nxt = tn_nxt;
                end else if (n > {1'b0, adapt_interval}) begin
                  v1 = {1'b0, vn_nxt} + 9'd1;
                  ac_nxt = 4'd0;
                  if (v1 >= {1'b0, voltage_ceiling}) begin
                    vn_nxt = voltage_ceiling;
                    we = 1'b1; wa = b; wd = {voltage_ceiling, tl_nxt};
                    rdbg_nxt = 8'(b);
                  end else vn_nxt = v1[7:0];
                end else ac_nxt = n[3:0];
                rv_nxt = vn_nxt;
              end
              ov_nxt = 1'b1; odl_nxt = 1'b0; oti_nxt = 1'b0;
            end
          end
        end
      end
      default: st_nxt = S_READ;
    endcase
  end

  always_comb begin
    if (q_item.tick) raddr = bucket_of(tn_r);
    else raddr = bucket_of({1'b0, q_item.temp});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      vld_r <= '0;
      phase_r <= 1'b0; sl_r <= avoc_pkg::STARTUP_RST; ac_r <= 4'd0; oc_r <= 4'd0;
      refp_r <= avoc_pkg::RESET_PERIOD; vn_r <= avoc_pkg::FLOOR_RST;
      tn_r <= avoc_pkg::RESET_TEMP; tb_r <= avoc_pkg::RESET_TEMP;
      tl_r <= 8'd0; td_r <= 8'd0; rt_r <= 8'd0; rv_r <= 8'd0; rp_r <= 16'd0;
      rdbg_r <= 8'd0; ov_r <= 1'b0; odl_r <= 1'b0; oti_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      phase_r <= phase_nxt; sl_r <= sl_nxt; ac_r <= ac_nxt; oc_r <= oc_nxt;
      refp_r <= refp_nxt; vn_r <= vn_nxt; tn_r <= tn_nxt; tb_r <= tb_nxt;
      tl_r <= tl_nxt; td_r <= td_nxt; rt_r <= rt_nxt; rv_r <= rv_nxt;
      rp_r <= rp_nxt; rdbg_r <= rdbg_nxt;
      ov_r <= ov_nxt; odl_r <= odl_nxt; oti_r <= oti_nxt;
      if (we) vld_r[wa] <= 1'b1;
      if (st_r == S_READ) rd_vld_r <= vld_r[raddr] || (we && wa == raddr);
    end
    if (we) mem[wa] <= wd;
    if (st_r == S_READ) rd_data_r <= (we && wa == raddr) ? wd : mem[raddr];
  end

  assign out_valid = ov_r;
  assign out_trim_feedback = rt_r;
  assign out_voltage_code = rv_r;
  assign out_period_report = rp_r;
  assign out_debug_bucket = rdbg_r[5:0];
  assign out_deadlock_reset = odl_r;
  assign out_temp_invalid = oti_r;

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_deadlock_reset && out_temp_invalid))
    else $error("both result flags set");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_voltage_code))
    else $error("stalled result changed");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("executed without queued item");
endmodule
`default_nettype wire

[src/adaptive_voltage_osccal_controller_unit.sv]
// Top level of the adaptive voltage and oscillator trim controller.
// Items are processed one at a time: a bucket memory read, then an update and write-back.
// An item is not completed while the result register holds a stalled result.
// A two-entry queue decouples the input from a stalled result register.
// Synchronous active-low reset restores control state; table entries read empty until written.
// Depends on avoc_pkg, avoc_front and avoc_back.
`default_nettype none
module adaptive_voltage_osccal_controller_unit #(
  parameter int BUCKETS = avoc_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_frame_tag,
  input  wire logic [7:0]  in_frame_checksum,
  input  wire logic [6:0]  in_temperature,
  input  wire logic [7:0]  in_trim_in,
  input  wire logic [7:0]  in_factory_trim,
  input  wire logic [7:0]  in_reset_flag,
  input  wire logic [15:0] in_elapsed_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_trim_feedback,
  output logic [7:0]       out_voltage_code,
  output logic [15:0]      out_period_report,
  output logic [5:0]       out_debug_bucket,
  output logic             out_deadlock_reset,
  output logic             out_temp_invalid,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [7:0] gc_r, fl_r, ce_r;
  logic [3:0] ai_r, dl_r, sf_r;
  logic [15:0] mg_r;
  avoc_pkg::item_t in_item, q_item;
  logic q_valid, pop;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[4:2];
  assign in_item = '{tick: in_kind, tag: in_frame_tag, chk: in_frame_checksum,
                     temp: in_temperature, trim: in_trim_in, fact: in_factory_trim,
                     rflag: in_reset_flag, elapsed: in_elapsed_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r <= avoc_pkg::GOOD_CHK_RST; ai_r <= avoc_pkg::ADAPT_RST;
      mg_r <= avoc_pkg::MARGIN_RST; fl_r <= avoc_pkg::FLOOR_RST;
      ce_r <= avoc_pkg::CEIL_RST; dl_r <= avoc_pkg::DEADLOCK_RST;
      sf_r <= avoc_pkg::STARTUP_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      unique case (idx)
        avoc_pkg::REG_GOOD_CHK: gc_r <= cfg_pwdata[7:0];
        avoc_pkg::REG_ADAPT:    ai_r <= cfg_pwdata[3:0];
        avoc_pkg::REG_MARGIN:   mg_r <= cfg_pwdata[15:0];
        avoc_pkg::REG_FLOOR:    fl_r <= cfg_pwdata[7:0];
        avoc_pkg::REG_CEIL:     ce_r <= cfg_pwdata[7:0];
        avoc_pkg::REG_DEADLOCK: dl_r <= cfg_pwdata[3:0];
        avoc_pkg::REG_STARTUP:  sf_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      avoc_pkg::REG_GOOD_CHK: cfg_prdata = {24'd0, gc_r};
      avoc_pkg::REG_ADAPT:    cfg_prdata = {28'd0, ai_r};
      avoc_pkg::REG_MARGIN:   cfg_prdata = {16'd0, mg_r};
      avoc_pkg::REG_FLOOR:    cfg_prdata = {24'd0, fl_r};
      avoc_pkg::REG_CEIL:     cfg_prdata = {24'd0, ce_r};
      avoc_pkg::REG_DEADLOCK: cfg_prdata = {28'd0, dl_r};
      avoc_pkg::REG_STARTUP:  cfg_prdata = {28'd0, sf_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  avoc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .pop, .q_valid, .q_item
  );

  avoc_back #(.BUCKETS(BUCKETS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop,
    .good_checksum(gc_r), .adapt_interval(ai_r), .period_margin(mg_r),
    .voltage_floor(fl_r), .voltage_ceiling(ce_r), .deadlock_limit(dl_r),
    .out_valid, .out_stall, .out_trim_feedback, .out_voltage_code,
    .out_period_report, .out_debug_bucket, .out_deadlock_reset, .out_temp_invalid
  );
endmodule
`default_nettype wire

[test/tb_adaptive_voltage_osccal_controller_unit.sv]
// Self-checking testbench for adaptive_voltage_osccal_controller_unit.
// A scoreboard class predicts every result from the accepted transfers; depends on avoc_pkg.
// Directed and random frames, ticks and stalls, and APB register settings drive the block.
`default_nettype none
module tb_adaptive_voltage_osccal_controller_unit;

  localparam int LIMIT = 400000;
  localparam int NBUCK = 64;

  typedef struct {
    logic [7:0]  trim;
    logic [7:0]  volt;
    logic [15:0] period;
    logic [5:0]  dbg;
    logic        dl;
    logic        inv;
  } reply_t;

  class osccal_scoreboard;
    logic [7:0]  good_chk, floor_v, ceil_v;
    logic [3:0]  adapt_iv, dead_lim, start_cfg;
    logic [15:0] margin;
    logic [7:0]  last_tag, volt_now, temp_now, temp_before, trim_last, trim_def;
    logic        phase;
    logic [3:0]  start_left, adapt_cnt, ovf_cnt;
    logic [15:0] ref_period;
    logic [7:0]  tab_v[NBUCK];
    logic [7:0]  tab_t[NBUCK];
    logic [7:0]  r_trim, r_volt;
    logic [15:0] r_period;
    logic [5:0]  r_dbg;
    reply_t      expq[$];
    int          errors;

    function new();
      good_chk = 62; adapt_iv = 10; margin = 100; floor_v = 200; ceil_v = 254;
      dead_lim = 5; start_cfg = 7;
      last_tag = 0; phase = 0; start_left = start_cfg; ref_period = avoc_pkg::RESET_PERIOD;
      volt_now = floor_v; adapt_cnt = 0;
      temp_now = avoc_pkg::RESET_TEMP; temp_before = avoc_pkg::RESET_TEMP;
      trim_last = 0; trim_def = 0; ovf_cnt = 0;
      for (int i = 0; i < NBUCK; i++) begin
        tab_v[i] = avoc_pkg::EMPTY_VOLT;
        tab_t[i] = 0;
      end
      r_trim = 0; r_volt = 0; r_period = 0; r_dbg = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        avoc_pkg::REG_GOOD_CHK: good_chk = v[7:0];
        avoc_pkg::REG_ADAPT:    adapt_iv = v[3:0];
        avoc_pkg::REG_MARGIN:   margin = v[15:0];
        avoc_pkg::REG_FLOOR:    floor_v = v[7:0];
        avoc_pkg::REG_CEIL:     ceil_v = v[7:0];
        avoc_pkg::REG_DEADLOCK: dead_lim = v[3:0];
        avoc_pkg::REG_STARTUP:  start_cfg = v[3:0];
        default: ;
      endcase
    endfunction

    function int bucket_of(logic [7:0] t);
      int b;
      b = t / 2;
      return (b >= NBUCK) ? NBUCK - 1 : b;
    endfunction

    function void store(int b, logic [7:0] v, logic [7:0] t);
      tab_v[b] = v;
      tab_t[b] = t;
      r_dbg = b[5:0];
    endfunction

    function void push(logic dl, logic inv);
      reply_t r;
      r.trim = r_trim; r.volt = r_volt; r.period = r_period; r.dbg = r_dbg;
      r.dl = dl; r.inv = inv;
      expq.push_back(r);
    endfunction

    function void note_item(avoc_pkg::item_t it);
      int b, n;
      if (it.tick) begin
        if (ovf_cnt < 15) ovf_cnt++;
        if (ovf_cnt <= dead_lim) return;
        volt_now = floor_v;
        trim_last = trim_def;
        b = bucket_of(temp_now);
        if (tab_v[b] != avoc_pkg::EMPTY_VOLT) store(b, avoc_pkg::EMPTY_VOLT, trim_last);
        ovf_cnt = 0;
        push(1, 0);
        return;
      end
      if (it.tag == last_tag) return;
      last_tag = it.tag;
      ovf_cnt = 0;
      trim_def = it.fact;
      if (it.tag == avoc_pkg::AFTER_RESET)
        store(bucket_of(temp_now), volt_now - 8'd2, trim_last);
      if (it.temp == avoc_pkg::TEMP_INVALID) begin
        push(0, 1);
        return;
      end
      trim_last = it.trim;
      if (it.rflag == avoc_pkg::AFTER_RESET) volt_now = volt_now - 8'd2;
      temp_now = {1'b0, it.temp};
      b = bucket_of(temp_now);
      if (!phase) begin
        if (start_left > 0) begin
          start_left--;
          ref_period = it.elapsed;
          r_period = it.elapsed;
        end else begin
          phase = 1;
        end
        r_trim = trim_last;
        if (it.chk != good_chk) begin
          volt_now = volt_now - 8'd2;
        end else begin
          n = adapt_cnt + 1;
          if (n > adapt_iv) begin
            volt_now = volt_now + 8'd1;
            adapt_cnt = 0;
          end else begin
            adapt_cnt = n[3:0];
          end
        end
        r_volt = volt_now;
        temp_before = temp_now;
      end else begin
        r_period = it.elapsed;
        if (int'(it.elapsed) > int'(ref_period) + int'(margin))
          r_trim = trim_last + 8'd1;
        else if (ref_period >= margin && int'(it.elapsed) < int'(ref_period) - int'(margin))
          r_trim = trim_last - 8'd1;
        else
          r_trim = trim_last;
        if (it.chk != good_chk) begin
          if (int'(volt_now) < int'(floor_v) + 2) begin
            volt_now = floor_v;
            r_trim = trim_def;
            store(b, avoc_pkg::EMPTY_VOLT, trim_last);
          end else begin
            volt_now = volt_now - 8'd2;
            store(b, volt_now, trim_last);
          end
          temp_before = temp_now;
        end else if (tab_v[b] != avoc_pkg::EMPTY_VOLT) begin
          volt_now = tab_v[b];
          r_trim = tab_t[b];
          temp_before = temp_now;
        end else if (int'(temp_now) + 2 < int'(temp_before)) begin
          volt_now = floor_v;
          temp_before = temp_now;
        end else begin
          n = adapt_cnt + 1;
          if (n > adapt_iv) begin
            if (int'(volt_now) + 1 >= int'(ceil_v)) begin
              volt_now = ceil_v;
              store(b, volt_now, trim_last);
            end else begin
              volt_now = volt_now + 8'd1;
            end
            adapt_cnt = 0;
          end else begin
            adapt_cnt = n[3:0];
          end
        end
        r_volt = volt_now;
      end
      push(0, 0);
    endfunction

    function void check_reply(reply_t got);
      reply_t e;
      if (expq.size() == 0) begin
        $error("unexpected result transfer: trim %0d volt %0d", got.trim, got.volt);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.trim !== e.trim) begin
        $error("trim_feedback expected %0d actual %0d", e.trim, got.trim); errors++;
      end
      if (got.volt !== e.volt) begin
        $error("voltage_code expected %0d actual %0d", e.volt, got.volt); errors++;
      end
      if (got.period !== e.period) begin
        $error("period_report expected %0d actual %0d", e.period, got.period); errors++;
      end
      if (got.dbg !== e.dbg) begin
        $error("debug_bucket expected %0d actual %0d", e.dbg, got.dbg); errors++;
      end
      if (got.dl !== e.dl) begin
        $error("deadlock_reset expected %0d actual %0d", e.dl, got.dl); errors++;
      end
      if (got.inv !== e.inv) begin
        $error("temp_invalid expected %0d actual %0d", e.inv, got.inv); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_kind;
  logic [7:0]  in_frame_tag, in_frame_checksum, in_trim_in, in_factory_trim, in_reset_flag;
  logic [6:0]  in_temperature;
  logic [15:0] in_elapsed_count;
  logic        out_valid, out_stall;
  logic [7:0]  out_trim_feedback, out_voltage_code;
  logic [15:0] out_period_report;
  logic [5:0]  out_debug_bucket;
  logic        out_deadlock_reset, out_temp_invalid;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  adaptive_voltage_osccal_controller_unit dut (.*);

  osccal_scoreboard sb;
  int   cycles;
  int   results_seen;
  bit   quiet;
  logic [7:0] prev_tag;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int burst, hold;
    bit held;
    reply_t got;
    burst = 0; hold = 0; held = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.trim = out_trim_feedback; got.volt = out_voltage_code;
        got.period = out_period_report; got.dbg = out_debug_bucket;
        got.dl = out_deadlock_reset; got.inv = out_temp_invalid;
        sb.check_reply(got);
        results_seen++;
      end
      @(negedge clk);
      if (results_seen == 40 && !held) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 6) - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic send_item(avoc_pkg::item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1;
    in_kind <= it.tick; in_frame_tag <= it.tag; in_frame_checksum <= it.chk;
    in_temperature <= it.temp; in_trim_in <= it.trim; in_factory_trim <= it.fact;
    in_reset_flag <= it.rflag; in_elapsed_count <= it.elapsed;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (!it.tick) prev_tag = it.tag;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic write_all(logic [7:0] g, logic [3:0] a, logic [15:0] m, logic [7:0] f,
                           logic [7:0] c, logic [3:0] d, logic [3:0] s);
    write_reg(avoc_pkg::REG_GOOD_CHK, 32'(g));
    write_reg(avoc_pkg::REG_ADAPT, 32'(a));
    write_reg(avoc_pkg::REG_MARGIN, 32'(m));
    write_reg(avoc_pkg::REG_FLOOR, 32'(f));
    write_reg(avoc_pkg::REG_CEIL, 32'(c));
    write_reg(avoc_pkg::REG_DEADLOCK, 32'(d));
    write_reg(avoc_pkg::REG_STARTUP, 32'(s));
  endtask

  function automatic avoc_pkg::item_t frame(logic [7:0] tag, logic [7:0] chk,
                                            logic [6:0] temp, logic [7:0] rflag,
                                            logic [15:0] el);
    avoc_pkg::item_t it;
    it.tick = 0; it.tag = tag; it.chk = chk; it.temp = temp;
    it.trim = 8'($urandom_range(0, 255)); it.fact = 8'($urandom_range(0, 255));
    it.rflag = rflag; it.elapsed = el;
    return it;
  endfunction

  function automatic avoc_pkg::item_t rand_frame();
    avoc_pkg::item_t it;
    logic [7:0] tag;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) tag = prev_tag;
    else if (r < 14) tag = avoc_pkg::AFTER_RESET;
    else begin
      tag = 8'($urandom_range(0, 255));
      if (tag == prev_tag) tag = ~tag;
    end
    it = frame(tag, ($urandom_range(0, 9) < 6) ? sb.good_chk : 8'($urandom_range(0, 255)),
               7'($urandom_range(0, 99) < 6 ? avoc_pkg::TEMP_INVALID :
                  ($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(40, 60))),
               ($urandom_range(0, 19) == 0) ? avoc_pkg::AFTER_RESET : 8'($urandom_range(0, 255)),
               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'(50000 + $urandom_range(0, 400)));
    return it;
  endfunction

  task automatic random_items(int count, int pause_at);
    avoc_pkg::item_t it;
    int k;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom_range(1, 9);
        for (int j = 0; j < k; j++) begin
          it = rand_frame();
          it.tick = 1;
          send_item(it);
        end
      end else begin
        send_item(rand_frame());
      end
    end
  endtask

  initial begin : stimulus
    avoc_pkg::item_t t;
    sb = new();
    cycles = 0; results_seen = 0; quiet = 0; prev_tag = 0;
    rst_n = 0; in_valid = 0; in_kind = 0; in_frame_tag = 0; in_frame_checksum = 0;
    in_temperature = 0; in_trim_in = 0; in_factory_trim = 0; in_reset_flag = 0;
    in_elapsed_count = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_item(frame(0, 62, 50, 0, 50200));
    send_item(frame(1, 62, 50, 0, 50200));
    send_item(frame(avoc_pkg::AFTER_RESET, 0, 0, avoc_pkg::AFTER_RESET, 0));
    send_item(frame(3, 255, 127, 255, 65535));
    send_item(frame(4, 62, avoc_pkg::TEMP_INVALID, 0, 50200));
    send_item(frame(5, 62, 101, avoc_pkg::AFTER_RESET, 50200));
    send_item(frame(6, 62, 50, 0, 50200));
    send_item(frame(7, 62, 52, 0, 50200));
    send_item(frame(8, 62, 52, 0, 50500));
    send_item(frame(9, 62, 52, 0, 49000));
    send_item(frame(10, 62, 40, 0, 50200));
    send_item(frame(11, 1, 40, 0, 50200));
    send_item(frame(11, 1, 40, 0, 50200));
    send_item(frame(12, 62, 40, 0, 50200));
    send_item(frame(avoc_pkg::AFTER_RESET, 62, 44, 0, 50200));
    t = frame(13, 62, 44, 0, 0);
    t.tick = 1;
    repeat (7) send_item(t);
    send_item(frame(14, 62, 44, 0, 50200));
    random_items(60, -1);
    drain();

    write_all(0, 1, 0, 0, 255, 0, 15);
    random_items(60, 30);
    drain();
    write_all(255, 15, 65535, 255, 0, 15, 0);
    random_items(40, -1);
    drain();
    write_all(62, 3, 200, 180, 230, 3, 5);
    random_items(50, -1);
    quiet = 1;
    random_items(40, -1);
    drain();

    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/avoc_pkg.sv
src/avoc_front.sv
src/avoc_back.sv
src/adaptive_voltage_osccal_controller_unit.sv
test/tb_adaptive_voltage_osccal_controller_unit.sv
